@@ sv/ncl_pkg.sv @@
// ----------------------------------------------------------------------------
// ncl_pkg: shared types and constants of the nearest-centroid labeler
// Field widths, item codes and the control/status structs between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ncl_pkg;

  localparam int SLOT_W  = 6;
  localparam int LABEL_W = 6;
  localparam int COUNT_W = 7;
  localparam int DIST_W  = 50;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd40;
  localparam logic [DIST_W-1:0]  DIST_MAX    = {DIST_W{1'b1}};

  // Item codes carried on the mode field.
  localparam logic MODE_LOAD     = 1'b0;
  localparam logic MODE_CLASSIFY = 1'b1;

  typedef struct packed {
    logic wr_en;       // write the incoming point into the centroid table
    logic capture;     // latch the incoming point for a search
    logic issue;       // read one table entry this cycle
    logic issue_last;  // the entry read this cycle is the last one searched
    logic out_load;    // move the search result into the output register
  } ncl_cmd_t;

  typedef struct packed {
    logic done;        // last distance of the search has been compared
    logic out_free;    // output register can take a result this cycle
  } ncl_status_t;

endpackage

`default_nettype wire

@@ sv/ncl_if.sv @@
// ----------------------------------------------------------------------------
// ncl_if: channel interfaces of the nearest-centroid labeler
// Point channel (load or classify items) and result channel, each with a
// valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ncl_in_if #(
  parameter int COORD_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [ncl_pkg::SLOT_W-1:0]    slot;
  logic signed [COORD_BITS-1:0]  coord_x;
  logic signed [COORD_BITS-1:0]  coord_y;
  logic signed [COORD_BITS-1:0]  coord_z;

  modport source (output valid, mode, slot, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, mode, slot, coord_x, coord_y, coord_z, output ready);
endinterface

interface ncl_out_if;
  logic                         valid;
  logic                         ready;
  logic [ncl_pkg::LABEL_W-1:0]  label;
  logic [ncl_pkg::DIST_W-1:0]   best_distance_sq;

  modport source (output valid, label, best_distance_sq, input ready);
  modport sink   (input valid, label, best_distance_sq, output ready);
endinterface

`default_nettype wire

@@ sv/ncl_ram.sv @@
// ----------------------------------------------------------------------------
// ncl_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ncl_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ sv/ncl_ctrl.sv @@
// ----------------------------------------------------------------------------
// ncl_ctrl: controller of the nearest-centroid labeler
// Holds the centroid count register, takes input transactions, sequences the
// table reads of a search and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ncl_ctrl #(
  parameter int  MAX_CENTROIDS = 64,
  localparam int AW            = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [ncl_pkg::COUNT_W-1:0]   cfg_data,
  input  wire logic                          in_valid,
  input  wire logic                          in_mode,
  input  wire logic [ncl_pkg::SLOT_W-1:0]    in_slot,
  output      logic                          in_ready,
  output      ncl_pkg::ncl_cmd_t             cmd,
  output      logic [AW-1:0]                 rd_addr,
  input  wire ncl_pkg::ncl_status_t          status
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0]                   state_r, state_nxt;
  logic [ncl_pkg::COUNT_W-1:0]  count_r;
  logic [AW-1:0]                idx_r, idx_nxt;
  logic [AW-1:0]                last_r, last_nxt;
  logic                         accept;
  int                           count_i;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign rd_addr  = idx_r;

  // Searched entries: a count of zero acts as one, a count above the table
  // size acts as the table size.
  always_comb begin
    count_i = int'(count_r);
    if (count_i == 0) begin
      count_i = 1;
    end
    if (count_i > MAX_CENTROIDS) begin
      count_i = MAX_CENTROIDS;
    end
  end

  always_comb begin
    state_nxt          = state_r;
    idx_nxt            = idx_r;
    last_nxt           = last_r;
    cmd                = '0;
    cmd.wr_en          = accept && (in_mode == ncl_pkg::MODE_LOAD) &&
                         (int'(in_slot) < MAX_CENTROIDS);
    cmd.capture        = accept && (in_mode == ncl_pkg::MODE_CLASSIFY);
    case (state_r)
      ST_IDLE: begin
        if (cmd.capture) begin
          idx_nxt   = '0;
          last_nxt  = AW'(count_i - 1);
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.issue      = 1'b1;
        cmd.issue_last = (idx_r == last_r);
        if (idx_r == last_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (status.done) begin
          if (status.out_free) begin
            cmd.out_load = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= ncl_pkg::COUNT_RESET;
      idx_r   <= '0;
      last_r  <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      last_r  <= last_nxt;
      if (cfg_we) begin
        count_r <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/ncl_datapath.sv @@
// ----------------------------------------------------------------------------
// ncl_datapath: distance pipeline of the nearest-centroid labeler
// Centroid table, a five-stage squared-distance pipeline that takes one
// table entry per cycle, the running minimum and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ncl_datapath #(
  parameter int  MAX_CENTROIDS = 64,
  parameter int  COORD_BITS    = 24,
  localparam int AW            = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire ncl_pkg::ncl_cmd_t              cmd,
  input  wire logic [AW-1:0]                  rd_addr,
  output      ncl_pkg::ncl_status_t           status,
  input  wire logic [ncl_pkg::SLOT_W-1:0]     in_slot,
  input  wire logic signed [COORD_BITS-1:0]   in_x,
  input  wire logic signed [COORD_BITS-1:0]   in_y,
  input  wire logic signed [COORD_BITS-1:0]   in_z,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic [ncl_pkg::LABEL_W-1:0]    out_label,
  output      logic [ncl_pkg::DIST_W-1:0]     out_dist
);

  localparam int CB = COORD_BITS;
  localparam int EW = 3 * CB;
  localparam int QW = 2 * CB;
  localparam int SW = (QW + 2 > ncl_pkg::DIST_W) ? QW + 2 : ncl_pkg::DIST_W;

  // Point under search.
  logic signed [CB-1:0] px_r, py_r, pz_r;

  // Table read (stage 1).
  logic [EW-1:0]        rdata;
  logic                 v1_r, last1_r;
  logic [AW-1:0]        idx1_r;

  // Absolute differences (stage 2).
  logic [CB-1:0]        dx_r, dy_r, dz_r;
  logic                 v2_r, last2_r;
  logic [AW-1:0]        idx2_r;

  // Squares (stage 3).
  logic [QW-1:0]        qx_r, qy_r, qz_r;
  logic                 v3_r, last3_r;
  logic [AW-1:0]        idx3_r;

  // Saturated squared distance (stage 4).
  logic [ncl_pkg::DIST_W-1:0] dist_r;
  logic                 v4_r, last4_r;
  logic [AW-1:0]        idx4_r;

  // Running minimum (stage 5).
  logic [ncl_pkg::DIST_W-1:0] best_r;
  logic [AW-1:0]        best_idx_r;
  logic                 done_r;

  // Output register.
  logic                 out_valid_r;
  logic [ncl_pkg::LABEL_W-1:0] out_label_r;
  logic [ncl_pkg::DIST_W-1:0]  out_dist_r;

  logic signed [CB:0]   cx, cy, cz;
  logic signed [CB:0]   ex, ey, ez;
  logic [SW-1:0]        sum;
  logic [ncl_pkg::DIST_W-1:0] sum_sat;

  ncl_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_CENTROIDS)
  ) u_table (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (AW'(in_slot)),
    .wdata ({in_x, in_y, in_z}),
    .re    (cmd.issue),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // Differences in one extra bit so they cannot overflow.
  always_comb begin
    cx = (CB+1)'(signed'(rdata[EW-1 -: CB]));
    cy = (CB+1)'(signed'(rdata[2*CB-1 -: CB]));
    cz = (CB+1)'(signed'(rdata[CB-1:0]));
    ex = (CB+1)'(px_r) - cx;
    ey = (CB+1)'(py_r) - cy;
    ez = (CB+1)'(pz_r) - cz;
  end

  always_comb begin
    sum = SW'(qx_r) + SW'(qy_r) + SW'(qz_r);
    if (sum > SW'(ncl_pkg::DIST_MAX)) begin
      sum_sat = ncl_pkg::DIST_MAX;
    end else begin
      sum_sat = ncl_pkg::DIST_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px_r <= in_x;
      py_r <= in_y;
      pz_r <= in_z;
    end
    idx1_r  <= rd_addr;
    last1_r <= cmd.issue_last;

    dx_r    <= CB'(ex[CB] ? -ex : ex);
    dy_r    <= CB'(ey[CB] ? -ey : ey);
    dz_r    <= CB'(ez[CB] ? -ez : ez);
    idx2_r  <= idx1_r;
    last2_r <= last1_r;

    qx_r    <= QW'(dx_r) * QW'(dx_r);
    qy_r    <= QW'(dy_r) * QW'(dy_r);
    qz_r    <= QW'(dz_r) * QW'(dz_r);
    idx3_r  <= idx2_r;
    last3_r <= last2_r;

    dist_r  <= sum_sat;
    idx4_r  <= idx3_r;
    last4_r <= last3_r;

    // The search always starts at entry zero; a strict compare keeps the
    // lowest index on ties.
    if (v4_r && ((idx4_r == '0) || (dist_r < best_r))) begin
      best_r     <= dist_r;
      best_idx_r <= idx4_r;
    end

    if (cmd.out_load) begin
      out_label_r <= ncl_pkg::LABEL_W'(best_idx_r);
      out_dist_r  <= best_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r   <= cmd.issue;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      v4_r   <= v3_r;
      done_r <= v4_r && last4_r;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.done     = done_r;
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_label = out_label_r;
  assign out_dist  = out_dist_r;

endmodule

`default_nettype wire

@@ sv/nearest_centroid_labeler.sv @@
// ----------------------------------------------------------------------------
// nearest_centroid_labeler: k-means assignment step for 3-D points
// Each point item either loads a centroid into the table or is labeled with
// the index of its nearest loaded centroid by squared Euclidean distance.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  carries items: mode selects load (write coord_x/y/z to entry
//          slot) or classify (search entries 0 .. centroid_count-1).
//   out_if carries one transaction per classify item: label and
//          best_distance_sq; ties go to the lowest index.
//   cfg_we/cfg_data write centroid_count (0 acts as 1, values above
//          MAX_CENTROIDS act as MAX_CENTROIDS); write it only while idle.
// Timing:
//   Loads can follow each other every cycle while the block is idle.
//   A classify reads one table entry per cycle through a five-stage distance
//   pipeline; the input becomes ready again in the same cycle as the result
//   is offered, so no new item is taken while a classify is searched or its
//   result has not yet entered the output register.
// Reset clears the control state and sets centroid_count to 40; the table
// is not cleared and must be loaded before it is searched. A stalled result
// waits in the output register while the next item is accepted; a second
// result waits in the block until the first one is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_centroid_labeler #(
  parameter int MAX_CENTROIDS = 64,
  parameter int COORD_BITS    = 24
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [ncl_pkg::COUNT_W-1:0] cfg_data,
  ncl_in_if.sink                           in_if,
  ncl_out_if.source                        out_if
);

  localparam int AW = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;

  ncl_pkg::ncl_cmd_t    cmd;
  ncl_pkg::ncl_status_t status;
  logic [AW-1:0]        rd_addr;

  ncl_ctrl #(
    .MAX_CENTROIDS (MAX_CENTROIDS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_if.valid),
    .in_mode  (in_if.mode),
    .in_slot  (in_if.slot),
    .in_ready (in_if.ready),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .status   (status)
  );

  ncl_datapath #(
    .MAX_CENTROIDS (MAX_CENTROIDS),
    .COORD_BITS    (COORD_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .status    (status),
    .in_slot   (in_if.slot),
    .in_x      (in_if.coord_x),
    .in_y      (in_if.coord_y),
    .in_z      (in_if.coord_z),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_label (out_if.label),
    .out_dist  (out_if.best_distance_sq)
  );

endmodule

`default_nettype wire
